[hw/rtl/mcss_pkg.sv]
// Shared constants, types and defaults for the multiply carry sector statistics block.
package mcss_pkg;

  localparam int OPERAND_BITS_DEF = 20;

  // Carry chain columns resolved per pipeline stage.
  localparam int CHAIN_STEP = 8;

  localparam int SUM_W = 47;
  localparam int CNT_W = 41;

  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};
  localparam logic [CNT_W-1:0]        CNT_MAX = {1'b1, {(CNT_W-1){1'b0}}};

  typedef struct packed {
    logic keep;
    logic sec00;
    logic sec10;
    logic carry_low;
    logic eob;
  } flags_t;

endpackage

[hw/rtl/mcss_carry_pipe.sv]
// Column sum and pipelined carry chain of one operand pair, with keep decision and value.
module mcss_carry_pipe
  import mcss_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF,
  localparam int CW          = $clog2(OPERAND_BITS + 1),
  localparam int VW          = CW + 1
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [OPERAND_BITS-1:0] in_multiplicand,
  input  logic [OPERAND_BITS-1:0] in_multiplier,
  input  logic                    in_end_of_batch,
  output logic                    res_valid,
  output flags_t                  res_flags,
  output logic signed [VW-1:0]    res_val
);

  localparam int K    = OPERAND_BITS;
  localparam int COLS = 2 * K - 1;
  localparam int NSTG = (COLS + CHAIN_STEP - 1) / CHAIN_STEP;

  // Input register.
  logic           s0_valid_r;
  logic [K-1:0]   p_r;
  logic [K-1:0]   q_r;
  logic           s0_eob_r;

  // Stage 0 holds the column sums; stage t+1 holds carries after chunk t.
  logic [CW-1:0]  col_r   [NSTG+1][COLS];
  logic [CW-1:0]  col_nxt [NSTG+1][COLS];
  logic [CW-1:0]  car_r   [NSTG+1][COLS+1];
  logic [CW-1:0]  car_nxt [NSTG+1][COLS+1];
  logic           vld_r   [NSTG+1];
  logic           eob_r   [NSTG+1];
  logic           sa_r    [NSTG+1];
  logic           sc_r    [NSTG+1];

  logic [CW-1:0]  colsum [COLS];

  logic           srch_vld_r;
  flags_t         srch_flags_r;
  flags_t         srch_flags_nxt;
  logic signed [VW-1:0] srch_val_r;
  logic signed [VW-1:0] srch_val_nxt;

  // Column sums of the schoolbook product.
  always_comb begin
    for (int j = 0; j < COLS; j++) begin
      colsum[j] = '0;
      for (int i = 0; i < K; i++) begin
        if (j >= i && j - i < K) begin
          colsum[j] = colsum[j] + CW'(p_r[i] & q_r[j-i]);
        end
      end
    end
  end

  // Each stage resolves a chunk of the ripple carry chain.
  always_comb begin
    int            j;
    logic [CW:0]   sum;
    j   = 0;
    sum = '0;
    col_nxt[0] = colsum;
    car_nxt[0] = '{default: '0};
    for (int t = 0; t < NSTG; t++) begin
      col_nxt[t+1] = col_r[t];
      car_nxt[t+1] = car_r[t];
      for (int k = 0; k < CHAIN_STEP; k++) begin
        j = t * CHAIN_STEP + k;
        if (j < COLS) begin
          sum = {1'b0, col_r[t][j]} + {1'b0, car_nxt[t+1][j]};
          car_nxt[t+1][j+1] = sum[CW:1];
        end
      end
    end
  end

  // Highest nonzero carry, keep decision and pair value.
  always_comb begin
    logic          any_nz;
    logic [CW-1:0] cm;
    logic          pbit_hi;
    logic          pbit_top;
    logic          sa;
    logic          sc;
    any_nz = 1'b0;
    cm     = '0;
    for (int j = 1; j <= COLS; j++) begin
      if (car_r[NSTG][j] != '0) begin
        any_nz = 1'b1;
        cm     = car_r[NSTG][j-1];
      end
    end
    sa       = sa_r[NSTG];
    sc       = sc_r[NSTG];
    pbit_hi  = col_r[NSTG][COLS-1][0] ^ car_r[NSTG][COLS-1][0];
    pbit_top = car_r[NSTG][COLS][0];
    srch_flags_nxt.keep      = !(sa && sc) && pbit_hi && !pbit_top && any_nz;
    srch_flags_nxt.sec00     = !sa && !sc;
    srch_flags_nxt.sec10     = sa && !sc;
    srch_flags_nxt.carry_low = (car_r[NSTG][COLS-2] == '0);
    srch_flags_nxt.eob       = eob_r[NSTG];
    srch_val_nxt             = VW'({1'b0, cm}) - VW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
      vld_r      <= '{default: 1'b0};
      srch_vld_r <= 1'b0;
    end else if (adv) begin
      s0_valid_r <= in_valid;
      vld_r[0]   <= s0_valid_r;
      for (int s = 1; s <= NSTG; s++) begin
        vld_r[s] <= vld_r[s-1];
      end
      srch_vld_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_r      <= in_multiplicand;
      q_r      <= in_multiplier;
      s0_eob_r <= in_end_of_batch;
      col_r    <= col_nxt;
      car_r    <= car_nxt;
      eob_r[0] <= s0_eob_r;
      sa_r[0]  <= p_r[K-2];
      sc_r[0]  <= q_r[K-2];
      for (int s = 1; s <= NSTG; s++) begin
        eob_r[s] <= eob_r[s-1];
        sa_r[s]  <= sa_r[s-1];
        sc_r[s]  <= sc_r[s-1];
      end
      srch_flags_r <= srch_flags_nxt;
      srch_val_r   <= srch_val_nxt;
    end
  end

  assign res_valid = srch_vld_r;
  assign res_flags = srch_flags_r;
  assign res_val   = srch_val_r;

`ifndef ASSERT_OFF
  a_hold_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |-> srch_vld_r)
    else $error("pipeline held without a finished pair at its end");
  a_hold_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(srch_val_r) && $stable(srch_flags_r) && srch_vld_r))
    else $error("final pipeline stage changed while held");
  a_sector_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    srch_vld_r |-> !(srch_flags_r.sec00 && srch_flags_r.sec10))
    else $error("pair flagged for two sectors at once");
`endif

endmodule

[hw/rtl/mcss_accum.sv]
// Saturating sector accumulators and the registered batch result.
module mcss_accum
  import mcss_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF,
  localparam int CW          = $clog2(OPERAND_BITS + 1),
  localparam int VW          = CW + 1
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     res_valid,
  input  flags_t                   res_flags,
  input  logic signed [VW-1:0]     res_val,
  output logic                     adv,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SUM_W-1:0]  out_sum_sector00,
  output logic signed [SUM_W-1:0]  out_sum_sector10,
  output logic [CNT_W-1:0]         out_count_sector00,
  output logic [CNT_W-1:0]         out_count_sector10,
  output logic signed [SUM_W-1:0]  out_sum00_low_carry,
  output logic signed [SUM_W-1:0]  out_sum00_high_carry,
  output logic [CNT_W-1:0]         out_kept_total
);

  function automatic logic signed [SUM_W-1:0] sat_add(input logic signed [SUM_W-1:0] a,
                                                      input logic signed [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {a[SUM_W-1], a} + {b[SUM_W-1], b};
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? SUM_MIN : SUM_MAX;
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] n);
    sat_inc = (n >= CNT_MAX) ? n : n + CNT_W'(1);
  endfunction

  logic signed [SUM_W-1:0] acc_s00_r, acc_s00_nxt;
  logic signed [SUM_W-1:0] acc_s10_r, acc_s10_nxt;
  logic signed [SUM_W-1:0] acc_low_r, acc_low_nxt;
  logic signed [SUM_W-1:0] acc_high_r, acc_high_nxt;
  logic [CNT_W-1:0]        acc_c00_r, acc_c00_nxt;
  logic [CNT_W-1:0]        acc_c10_r, acc_c10_nxt;
  logic [CNT_W-1:0]        acc_tot_r, acc_tot_nxt;

  logic                    out_valid_r;
  logic signed [SUM_W-1:0] out_s00_r, out_s10_r, out_low_r, out_high_r;
  logic [CNT_W-1:0]        out_c00_r, out_c10_r, out_tot_r;

  logic                    take;
  logic                    kept;
  logic signed [SUM_W-1:0] add_v;

  // Only a batch end that finds the result register still waiting holds the pipe.
  assign adv  = !(res_valid && res_flags.eob && out_valid_r && out_stall);
  assign take = res_valid && adv;
  assign kept = take && res_flags.keep;

  always_comb begin
    add_v        = SUM_W'(res_val);
    acc_s00_nxt  = (kept && res_flags.sec00) ? sat_add(acc_s00_r, add_v) : acc_s00_r;
    acc_c00_nxt  = (kept && res_flags.sec00) ? sat_inc(acc_c00_r) : acc_c00_r;
    acc_low_nxt  = (kept && res_flags.sec00 && res_flags.carry_low) ?
                   sat_add(acc_low_r, add_v) : acc_low_r;
    acc_high_nxt = (kept && res_flags.sec00 && !res_flags.carry_low) ?
                   sat_add(acc_high_r, add_v) : acc_high_r;
    acc_s10_nxt  = (kept && res_flags.sec10) ? sat_add(acc_s10_r, add_v) : acc_s10_r;
    acc_c10_nxt  = (kept && res_flags.sec10) ? sat_inc(acc_c10_r) : acc_c10_r;
    acc_tot_nxt  = kept ? sat_inc(acc_tot_r) : acc_tot_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_s00_r   <= '0;
      acc_s10_r   <= '0;
      acc_low_r   <= '0;
      acc_high_r  <= '0;
      acc_c00_r   <= '0;
      acc_c10_r   <= '0;
      acc_tot_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (take && res_flags.eob) begin
        acc_s00_r   <= '0;
        acc_s10_r   <= '0;
        acc_low_r   <= '0;
        acc_high_r  <= '0;
        acc_c00_r   <= '0;
        acc_c10_r   <= '0;
        acc_tot_r   <= '0;
        out_valid_r <= 1'b1;
      end else begin
        acc_s00_r  <= acc_s00_nxt;
        acc_s10_r  <= acc_s10_nxt;
        acc_low_r  <= acc_low_nxt;
        acc_high_r <= acc_high_nxt;
        acc_c00_r  <= acc_c00_nxt;
        acc_c10_r  <= acc_c10_nxt;
        acc_tot_r  <= acc_tot_nxt;
        if (!out_stall) begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_flags.eob) begin
      out_s00_r  <= acc_s00_nxt;
      out_s10_r  <= acc_s10_nxt;
      out_low_r  <= acc_low_nxt;
      out_high_r <= acc_high_nxt;
      out_c00_r  <= acc_c00_nxt;
      out_c10_r  <= acc_c10_nxt;
      out_tot_r  <= acc_tot_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_sum_sector00     = out_s00_r;
  assign out_sum_sector10     = out_s10_r;
  assign out_count_sector00   = out_c00_r;
  assign out_count_sector10   = out_c10_r;
  assign out_sum00_low_carry  = out_low_r;
  assign out_sum00_high_carry = out_high_r;
  assign out_kept_total       = out_tot_r;

`ifndef ASSERT_OFF
  a_clear_after_batch: assert property (@(posedge clk) disable iff (!rst_n)
    (take && res_flags.eob) |=> (acc_tot_r == '0 && acc_c00_r == '0 && acc_s00_r == '0))
    else $error("accumulators not cleared after a batch end");
  a_c00_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    acc_c00_r <= acc_tot_r)
    else $error("sector 00 count exceeds kept total");
  a_c10_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    acc_c10_r <= acc_tot_r)
    else $error("sector 10 count exceeds kept total");
`endif

endmodule

[hw/rtl/multiply_carry_sector_stats.sv]
// Top level of the multiply carry sector statistics block.
//
// Input channel: one operand pair per request (in_multiplicand, in_multiplier,
// in_end_of_batch) under in_valid / in_stall. A request is taken at a rising edge
// with in_valid high and in_stall low. A new pair may be taken in every cycle.
// Each pair runs through an input register, a column sum stage, a carry chain
// cut into ceil((2*OPERAND_BITS-1)/8) stages of eight columns, a search stage
// for the highest carry, and the accumulators.
// Result channel: a request carrying the seven batch totals is produced only
// for a pair with in_end_of_batch set; the totals include that pair and the
// accumulators clear behind it. Throughput is one pair per cycle. The result
// sits in an output register, so pairs keep flowing while it waits; only a
// second batch end reaching the accumulators while the result is still
// stalled holds the pipeline, and then in_stall rises until the receiver
// takes the result.
// Reset (rst_n low, synchronous) empties the pipeline, drops any pending result
// and zeroes every accumulator.
module multiply_carry_sector_stats
  import mcss_pkg::*;
#(
  parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [OPERAND_BITS-1:0]  in_multiplicand,
  input  logic [OPERAND_BITS-1:0]  in_multiplier,
  input  logic                     in_end_of_batch,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [SUM_W-1:0]  out_sum_sector00,
  output logic signed [SUM_W-1:0]  out_sum_sector10,
  output logic [CNT_W-1:0]         out_count_sector00,
  output logic [CNT_W-1:0]         out_count_sector10,
  output logic signed [SUM_W-1:0]  out_sum00_low_carry,
  output logic signed [SUM_W-1:0]  out_sum00_high_carry,
  output logic [CNT_W-1:0]         out_kept_total
);

  localparam int CW = $clog2(OPERAND_BITS + 1);
  localparam int VW = CW + 1;

  logic                 adv;
  logic                 res_valid;
  flags_t               res_flags;
  logic signed [VW-1:0] res_val;

  assign in_stall = !adv;

  mcss_carry_pipe #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_pipe (
    .clk             (clk),
    .rst_n           (rst_n),
    .adv             (adv),
    .in_valid        (in_valid),
    .in_multiplicand (in_multiplicand),
    .in_multiplier   (in_multiplier),
    .in_end_of_batch (in_end_of_batch),
    .res_valid       (res_valid),
    .res_flags       (res_flags),
    .res_val         (res_val)
  );

  mcss_accum #(
    .OPERAND_BITS (OPERAND_BITS)
  ) u_accum (
    .clk                  (clk),
    .rst_n                (rst_n),
    .res_valid            (res_valid),
    .res_flags            (res_flags),
    .res_val              (res_val),
    .adv                  (adv),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_sum_sector00     (out_sum_sector00),
    .out_sum_sector10     (out_sum_sector10),
    .out_count_sector00   (out_count_sector00),
    .out_count_sector10   (out_count_sector10),
    .out_sum00_low_carry  (out_sum00_low_carry),
    .out_sum00_high_carry (out_sum00_high_carry),
    .out_kept_total       (out_kept_total)
  );

endmodule
